// ===== rtl/cru_pkg.sv =====
// ============================================================================
// Circle rasteriser package
// Shared constants for the circle rasteriser: action codes, rule codes and
// the fixed numbers of the Bresenham and midpoint decision rules.
// ============================================================================
package cru_pkg;

    // Action codes of an input item.
    localparam logic ACT_START = 1'b0;

    // Decision rule codes held in the configuration register.
    localparam logic ALG_MIDPOINT  = 1'b0;
    localparam logic ALG_BRESENHAM = 1'b1;

    // Decision rule constants.
    localparam int BRES_INIT   = 3;
    localparam int BRES_DIAG   = 10;
    localparam int BRES_AXIAL  = 6;
    localparam int MID_INIT    = 1;
    localparam int MID_STEP    = 1;

    // Eight symmetric pixels are emitted for every octant point.
    localparam int          PIX_IDX_W = 3;
    localparam logic [2:0]  LAST_IDX  = 3'd7;

    // Group queue geometry: two entries, one pointer bit.
    localparam int Q_PTR_W = 1;
    localparam int Q_CNT_W = 2;
    localparam logic [1:0] Q_FULL = 2'd2;

endpackage

// ===== rtl/circle_rasterizer_unit.sv =====
// ============================================================================
// Circle rasteriser
// Bresenham or midpoint circle scan: each drawing item yields the eight
// symmetric pixels of one octant point and advances to the next point.
// ============================================================================
//
//  Channel   Direction  Handshake                    Payload
//  -------   ---------  ---------------------------  -------------------------
//  cfg       in         i_cfg_valid / o_cfg_ready    i_cfg_algorithm_select
//  in        in         i_in_valid  / o_in_ready     action, centre, radius
//  out       out        o_out_valid / i_out_ready    pixel x/y, last, done
//
//  An item is taken whenever the two-entry group queue has room. The pixel
//  emitter sends eight pixels per drawing item at one per cycle while the
//  output is ready; a step while idle gives no pixels. The first pixel is
//  presented from the registered output stage, after the item's group has
//  passed through a queue entry. Reset is synchronous. Output stalls back
//  up through the queue to o_in_ready; configuration writes are never
//  stalled.
//
module circle_rasterizer_unit #(
    parameter int COORD_BITS = 11
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic                  i_cfg_algorithm_select,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic                  i_action,
    input  logic [COORD_BITS-1:0] i_center_x,
    input  logic [COORD_BITS-1:0] i_center_y,
    input  logic [COORD_BITS-2:0] i_radius,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic [COORD_BITS+1:0] o_pixel_x,
    output logic [COORD_BITS+1:0] o_pixel_y,
    output logic                  o_last_of_group,
    output logic                  o_circle_done
);

    localparam int GRP_W = 4 * COORD_BITS + 1;

    logic             w_push_valid, w_push_ready;
    logic [GRP_W-1:0] w_push_data;
    logic             w_pop_valid, w_pop_ready;
    logic [GRP_W-1:0] w_pop_data;

    // Front end: item intake and circle state.
    cru_front #(
        .COORD_BITS (COORD_BITS)
    ) u_front (
        .i_clk                  (i_clk),
        .i_rst_n                (i_rst_n),
        .i_cfg_valid            (i_cfg_valid),
        .o_cfg_ready            (o_cfg_ready),
        .i_cfg_algorithm_select (i_cfg_algorithm_select),
        .i_in_valid             (i_in_valid),
        .o_in_ready             (o_in_ready),
        .i_action               (i_action),
        .i_center_x             (i_center_x),
        .i_center_y             (i_center_y),
        .i_radius               (i_radius),
        .o_push_valid           (w_push_valid),
        .i_push_ready           (w_push_ready),
        .o_push_data            (w_push_data)
    );

    // Group queue between the two halves.
    cru_fifo #(
        .WIDTH (GRP_W)
    ) u_fifo (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_valid (w_push_valid),
        .o_wr_ready (w_push_ready),
        .i_wr_data  (w_push_data),
        .o_rd_valid (w_pop_valid),
        .i_rd_ready (w_pop_ready),
        .o_rd_data  (w_pop_data)
    );

    // Back end: pixel emitter.
    cru_back #(
        .COORD_BITS (COORD_BITS)
    ) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_grp_valid     (w_pop_valid),
        .o_grp_ready     (w_pop_ready),
        .i_grp_data      (w_pop_data),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_pixel_x       (o_pixel_x),
        .o_pixel_y       (o_pixel_y),
        .o_last_of_group (o_last_of_group),
        .o_circle_done   (o_circle_done)
    );

endmodule

// ===== rtl/cru_front.sv =====
// ============================================================================
// Circle rasteriser front end
// Accepts start and step items, holds the circle state, produces the current
// offset group and advances it under the selected decision rule.
// ============================================================================
module cru_front #(
    parameter int COORD_BITS = 11
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_valid,
    output logic                      o_cfg_ready,
    input  logic                      i_cfg_algorithm_select,
    input  logic                      i_in_valid,
    output logic                      o_in_ready,
    input  logic                      i_action,
    input  logic [COORD_BITS-1:0]     i_center_x,
    input  logic [COORD_BITS-1:0]     i_center_y,
    input  logic [COORD_BITS-2:0]     i_radius,
    output logic                      o_push_valid,
    input  logic                      i_push_ready,
    output logic [4*COORD_BITS:0]     o_push_data
);

    localparam int DEC_W = COORD_BITS + 3;
    localparam int CMP_W = COORD_BITS + 1;

    logic                          r_alg;
    logic                          r_active;
    logic signed [COORD_BITS-1:0]  r_ofs_x, n_ofs_x;
    logic signed [COORD_BITS-1:0]  r_ofs_y, n_ofs_y;
    logic signed [DEC_W-1:0]       r_dec, n_dec;
    logic [COORD_BITS-1:0]         r_cen_x, r_cen_y;

    logic                          w_start, w_draw, w_accept, w_done;
    logic signed [COORD_BITS-1:0]  w_cur_x, w_cur_y;
    logic [COORD_BITS-1:0]         w_cur_cx, w_cur_cy;
    logic signed [CMP_W-1:0]       w_x_e, w_y_e, w_nx_e, w_ny_e, w_sel_y_e;
    logic signed [DEC_W-1:0]       w_rad_d, w_init_d, w_cur_d, w_nx_d, w_ny_d;

    // Handshakes: configuration is always taken, items need a queue slot.
    assign o_cfg_ready  = 1'b1;
    assign o_in_ready   = i_push_ready;
    assign w_start      = (i_action == cru_pkg::ACT_START);
    assign w_draw       = w_start || r_active;
    assign w_accept     = i_in_valid && i_push_ready;
    assign o_push_valid = i_in_valid && w_draw;

    // Current point: fresh values on a start, held values on a step.
    always_comb begin
        w_rad_d = DEC_W'({1'b0, i_radius});
        if (r_alg == cru_pkg::ALG_BRESENHAM) begin
            w_init_d = DEC_W'(cru_pkg::BRES_INIT) - (w_rad_d <<< 1);
        end else begin
            w_init_d = DEC_W'(cru_pkg::MID_INIT) - w_rad_d;
        end
        w_cur_x  = w_start ? '0 : r_ofs_x;
        w_cur_y  = w_start ? {1'b0, i_radius} : r_ofs_y;
        w_cur_d  = w_start ? w_init_d : r_dec;
        w_cur_cx = w_start ? i_center_x : r_cen_x;
        w_cur_cy = w_start ? i_center_y : r_cen_y;
    end

    // Advance by one octant point under the selected rule.
    always_comb begin
        w_x_e  = CMP_W'(w_cur_x);
        w_y_e  = CMP_W'(w_cur_y);
        w_nx_e = w_x_e + CMP_W'(1);
        w_ny_e = w_y_e - CMP_W'(1);
        w_nx_d = DEC_W'(w_nx_e);
        w_ny_d = DEC_W'(w_ny_e);
        n_ofs_x = w_nx_e[COORD_BITS-1:0];
        if (r_alg == cru_pkg::ALG_BRESENHAM) begin
            w_done = (w_y_e < w_x_e);
            if (w_cur_d > DEC_W'(0)) begin
                w_sel_y_e = w_ny_e;
                n_dec = w_cur_d + ((w_nx_d - w_ny_d) <<< 2) + DEC_W'(cru_pkg::BRES_DIAG);
            end else begin
                w_sel_y_e = w_y_e;
                n_dec = w_cur_d + (w_nx_d <<< 2) + DEC_W'(cru_pkg::BRES_AXIAL);
            end
        end else begin
            if (w_cur_d[DEC_W-1]) begin
                w_sel_y_e = w_y_e;
                n_dec = w_cur_d + (w_nx_d <<< 1) + DEC_W'(cru_pkg::MID_STEP);
            end else begin
                w_sel_y_e = w_ny_e;
                n_dec = w_cur_d + ((w_nx_d - w_ny_d) <<< 1) + DEC_W'(cru_pkg::MID_STEP);
            end
            w_done = (w_sel_y_e <= w_nx_e);
        end
        n_ofs_y = w_sel_y_e[COORD_BITS-1:0];
    end

    // Group handed to the back end: done flag, offset pair and centre.
    assign o_push_data = {w_done, w_cur_y, w_cur_x, w_cur_cy, w_cur_cx};

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alg    <= cru_pkg::ALG_BRESENHAM;
            r_active <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_alg <= i_cfg_algorithm_select;
            end
            if (w_accept && w_draw) begin
                r_active <= !w_done;
            end
        end
    end

    // Circle state, updated on every drawing transfer.
    always_ff @(posedge i_clk) begin
        if (w_accept && w_draw) begin
            r_ofs_x <= n_ofs_x;
            r_ofs_y <= n_ofs_y;
            r_dec   <= n_dec;
            r_cen_x <= w_cur_cx;
            r_cen_y <= w_cur_cy;
        end
    end

endmodule

// ===== rtl/cru_fifo.sv =====
// ============================================================================
// Circle rasteriser group queue
// Two-entry queue that parts the front end from the pixel emitter.
// ============================================================================
module cru_fifo #(
    parameter int WIDTH = 45
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_wr_valid,
    output logic             o_wr_ready,
    input  logic [WIDTH-1:0] i_wr_data,
    output logic             o_rd_valid,
    input  logic             i_rd_ready,
    output logic [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0]                  r_mem [2];
    logic [cru_pkg::Q_PTR_W-1:0]       r_wr_ptr, r_rd_ptr;
    logic [cru_pkg::Q_CNT_W-1:0]       r_count;
    logic                              w_wr, w_rd;

    // Status and transfers.
    assign o_wr_ready = (r_count != cru_pkg::Q_FULL);
    assign o_rd_valid = (r_count != '0);
    assign o_rd_data  = r_mem[r_rd_ptr];
    assign w_wr       = i_wr_valid && o_wr_ready;
    assign w_rd       = o_rd_valid && i_rd_ready;

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_wr) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (w_rd) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            case ({w_wr, w_rd})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wr_ptr] <= i_wr_data;
        end
    end

endmodule

// ===== rtl/cru_back.sv =====
// ============================================================================
// Circle rasteriser pixel emitter
// Walks the eight symmetric pixels of the queued group, one per cycle while
// the output is ready, into a registered output stage.
// ============================================================================
module cru_back #(
    parameter int COORD_BITS = 11
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_grp_valid,
    output logic                      o_grp_ready,
    input  logic [4*COORD_BITS:0]     i_grp_data,
    output logic                      o_out_valid,
    input  logic                      i_out_ready,
    output logic [COORD_BITS+1:0]     o_pixel_x,
    output logic [COORD_BITS+1:0]     o_pixel_y,
    output logic                      o_last_of_group,
    output logic                      o_circle_done
);

    localparam int PIX_W = COORD_BITS + 2;

    logic [cru_pkg::PIX_IDX_W-1:0] r_idx;
    logic                          r_valid;
    logic [PIX_W-1:0]              r_px, r_py;
    logic                          r_last, r_done;

    logic                          w_load, w_grp_done, w_is_last;
    logic [COORD_BITS-1:0]         w_cx, w_cy, w_ox, w_oy, w_a, w_b;
    logic [PIX_W-1:0]              w_ae, w_be, w_px, w_py;

    // Unpack the head group.
    assign {w_grp_done, w_oy, w_ox, w_cy, w_cx} = i_grp_data;

    // A pixel is loaded when the output stage is empty or being drained.
    assign w_load      = i_grp_valid && (!r_valid || i_out_ready);
    assign w_is_last   = (r_idx == cru_pkg::LAST_IDX);
    assign o_grp_ready = (!r_valid || i_out_ready) && w_is_last;

    // Pixel index bit 2 swaps the axes, bit 0 and bit 1 negate the terms.
    always_comb begin
        w_a  = r_idx[2] ? w_oy : w_ox;
        w_b  = r_idx[2] ? w_ox : w_oy;
        w_ae = {{2{w_a[COORD_BITS-1]}}, w_a};
        w_be = {{2{w_b[COORD_BITS-1]}}, w_b};
        w_px = {2'b00, w_cx} + (r_idx[0] ? -w_ae : w_ae);
        w_py = {2'b00, w_cy} + (r_idx[1] ? -w_be : w_be);
    end

    // Output stage control and pixel counter.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= '0;
        end else begin
            if (w_load) begin
                r_valid <= 1'b1;
                r_idx   <= r_idx + 1'b1;
            end else if (i_out_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    // Output payload.
    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_px   <= w_px;
            r_py   <= w_py;
            r_last <= w_is_last;
            r_done <= w_grp_done;
        end
    end

    assign o_out_valid     = r_valid;
    assign o_pixel_x       = r_px;
    assign o_pixel_y       = r_py;
    assign o_last_of_group = r_last;
    assign o_circle_done   = r_done;

endmodule

// ===== rtl/cru_checker.sv =====
// ============================================================================
// Circle rasteriser port checker
// Watches the top-level ports for output handshake and group continuity.
// ============================================================================
module cru_checker #(
    parameter int COORD_BITS = 11
) (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  o_out_valid,
    input logic                  i_out_ready,
    input logic [COORD_BITS+1:0] o_pixel_x,
    input logic [COORD_BITS+1:0] o_pixel_y,
    input logic                  o_last_of_group,
    input logic                  o_circle_done
);

    // Reset empties the output stage.
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

    // A pending pixel is held until it is taken.
    a_valid_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("output valid dropped without transfer");

    // A stalled pixel keeps its payload.
    a_payload_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> $stable(o_pixel_x) && $stable(o_pixel_y)
            && $stable(o_last_of_group) && $stable(o_circle_done))
        else $error("output payload changed during stall");

    // Pixels of one group follow back to back and share the done flag.
    a_group_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_ready && !o_last_of_group
            |=> o_out_valid && (o_circle_done == $past(o_circle_done)))
        else $error("group broken before its last pixel");

endmodule

bind circle_rasterizer_unit cru_checker #(
    .COORD_BITS (COORD_BITS)
) u_cru_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_out_valid     (o_out_valid),
    .i_out_ready     (i_out_ready),
    .o_pixel_x       (o_pixel_x),
    .o_pixel_y       (o_pixel_y),
    .o_last_of_group (o_last_of_group),
    .o_circle_done   (o_circle_done)
);

// ===== tb/tb_circle_rasterizer_unit.sv =====
`timescale 1ns / 1ps
// ============================================================================
// Circle rasteriser testbench
// Drives start and step items into the rasteriser under both decision rules,
// predicts the eight symmetric pixels of every drawing item, and compares each
// output transfer with the oldest predicted pixel. Directed cases come first,
// then random circles with random idling on both channels.
// ============================================================================
module tb_circle_rasterizer_unit;

    localparam int CW             = 11;
    localparam int PW             = CW + 2;
    localparam int OW             = 11;
    localparam int DW             = 14;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SETTLE_CYCLES  = 8;
    localparam int TAIL_CYCLES    = 20;
    localparam int RANDOM_ITEMS   = 285;
    localparam logic ACT_STEP     = ~cru_pkg::ACT_START;

    typedef struct packed {
        logic [PW-1:0] px;
        logic [PW-1:0] py;
        logic          last;
        logic          done;
    } t_pixel;

    logic          i_clk;
    logic          i_rst_n;
    logic          i_cfg_valid;
    logic          o_cfg_ready;
    logic          i_cfg_algorithm_select;
    logic          i_in_valid;
    logic          o_in_ready;
    logic          i_action;
    logic [CW-1:0] i_center_x;
    logic [CW-1:0] i_center_y;
    logic [CW-2:0] i_radius;
    logic          o_out_valid;
    logic          i_out_ready;
    logic [PW-1:0] o_pixel_x;
    logic [PW-1:0] o_pixel_y;
    logic          o_last_of_group;
    logic          o_circle_done;

    // Shadow of the rasteriser state used for prediction.
    logic                 rule_sel;
    logic signed [OW-1:0] off_x;
    logic signed [OW-1:0] off_y;
    logic signed [DW-1:0] decision_val;
    logic [CW-1:0]        held_cx;
    logic [CW-1:0]        held_cy;
    logic                 circle_active;

    t_pixel expected_pixels[$];

    int  mismatches;
    int  items_sent;
    int  items_drawn;
    int  circles_started;
    int  pixels_checked;
    int  rule_writes;
    int  idle_cycles;
    int  ready_hold;
    bit  out_stalls_on;
    bit  in_gaps_on;

    circle_rasterizer_unit #(
        .COORD_BITS(CW)
    ) u_top (
        .i_clk                 (i_clk),
        .i_rst_n               (i_rst_n),
        .i_cfg_valid           (i_cfg_valid),
        .o_cfg_ready           (o_cfg_ready),
        .i_cfg_algorithm_select(i_cfg_algorithm_select),
        .i_in_valid            (i_in_valid),
        .o_in_ready            (o_in_ready),
        .i_action              (i_action),
        .i_center_x            (i_center_x),
        .i_center_y            (i_center_y),
        .i_radius              (i_radius),
        .o_out_valid           (o_out_valid),
        .i_out_ready           (i_out_ready),
        .o_pixel_x             (o_pixel_x),
        .o_pixel_y             (o_pixel_y),
        .o_last_of_group       (o_last_of_group),
        .o_circle_done         (o_circle_done)
    );

    // Free-running clock.
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Gap length: usually none or short, now and then a long one.
    function automatic int pick_gap();
        if ($urandom_range(0, 15) == 0)
            return $urandom_range(15, 50);
        if ($urandom_range(0, 2) == 0)
            return $urandom_range(1, 3);
        return 0;
    endfunction

    // Predict the pixel group of one accepted item and advance the shadow state.
    function automatic void predict_octant_point(input logic act, input logic [CW-1:0] cx_in,
                                                 input logic [CW-1:0] cy_in,
                                                 input logic [CW-2:0] rad);
        int     x, y, d, cx, cy, ox, oy, init;
        int     px[8];
        int     py[8];
        logic   done;
        t_pixel p;
        if (act == cru_pkg::ACT_START) begin
            held_cx = cx_in;
            held_cy = cy_in;
            off_x   = '0;
            off_y   = {1'b0, rad};
            if (rule_sel == cru_pkg::ALG_BRESENHAM)
                init = cru_pkg::BRES_INIT - 2 * int'(rad);
            else
                init = cru_pkg::MID_INIT - int'(rad);
            decision_val  = init[DW-1:0];
            circle_active = 1'b1;
            circles_started++;
        end else if (!circle_active) begin
            return;
        end

        x  = off_x;
        y  = off_y;
        d  = decision_val;
        ox = x;
        oy = y;
        cx = held_cx;
        cy = held_cy;

        // Advance one point under the rule in force at this moment.
        if (rule_sel == cru_pkg::ALG_BRESENHAM) begin
            done = (y < x);
            x = x + 1;
            if (d > 0) begin
                y = y - 1;
                d = d + 4 * (x - y) + cru_pkg::BRES_DIAG;
            end else begin
                d = d + 4 * x + cru_pkg::BRES_AXIAL;
            end
        end else begin
            x = x + 1;
            if (d < 0) begin
                d = d + 2 * x + cru_pkg::MID_STEP;
            end else begin
                y = y - 1;
                d = d + 2 * (x - y) + cru_pkg::MID_STEP;
            end
            done = (y <= x);
        end

        // Eight-way symmetry around the held centre.
        px[0] = cx + ox; py[0] = cy + oy;
        px[1] = cx - ox; py[1] = cy + oy;
        px[2] = cx + ox; py[2] = cy - oy;
        px[3] = cx - ox; py[3] = cy - oy;
        px[4] = cx + oy; py[4] = cy + ox;
        px[5] = cx - oy; py[5] = cy + ox;
        px[6] = cx + oy; py[6] = cy - ox;
        px[7] = cx - oy; py[7] = cy - ox;
        for (int k = 0; k < 8; k++) begin
            p.px   = px[k][PW-1:0];
            p.py   = py[k][PW-1:0];
            p.last = (k == int'(cru_pkg::LAST_IDX));
            p.done = done;
            expected_pixels.push_back(p);
        end

        off_x        = x[OW-1:0];
        off_y        = y[OW-1:0];
        decision_val = d[DW-1:0];
        if (done)
            circle_active = 1'b0;
        items_drawn++;
    endfunction

    // Send one item; valid stays high afterwards so that a following item can
    // go out back to back.
    task automatic send_item(input logic act, input logic [CW-1:0] cx, input logic [CW-1:0] cy,
                             input logic [CW-2:0] rad);
        int gap;
        gap = in_gaps_on ? pick_gap() : 0;
        @(negedge i_clk);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_action   <= act;
        i_center_x <= cx;
        i_center_y <= cy;
        i_radius   <= rad;
        do @(posedge i_clk); while (!o_in_ready);
        predict_octant_point(act, cx, cy, rad);
        items_sent++;
    endtask

    // Step item with a random, ignored payload.
    task automatic step_circle();
        send_item(ACT_STEP, CW'($urandom_range(0, 2047)), CW'($urandom_range(0, 2047)),
                  (CW-1)'($urandom_range(0, 1023)));
    endtask

    task automatic run_to_end();
        while (circle_active)
            step_circle();
    endtask

    task automatic idle_input();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
    endtask

    // Rule write, only once all pixels have come out and the block has settled.
    task automatic set_rule(input logic alg);
        idle_input();
        while (expected_pixels.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_valid            <= 1'b1;
        i_cfg_algorithm_select <= alg;
        do @(posedge i_clk); while (!o_cfg_ready);
        rule_sel = alg;
        rule_writes++;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic test_step_while_idle();
        send_item(ACT_STEP, 2047, 2047, 1023);
        send_item(ACT_STEP, 0, 0, 0);
    endtask

    // Reset rule is Bresenham: zero radius, largest radius at both corners,
    // a start that abandons a circle in progress, and a step after the end.
    task automatic test_bresenham_extremes();
        send_item(cru_pkg::ACT_START, 0, 0, 0);
        run_to_end();
        step_circle();
        send_item(cru_pkg::ACT_START, 2047, 2047, 1023);
        step_circle();
        step_circle();
        send_item(cru_pkg::ACT_START, 0, 0, 1023);
        step_circle();
        send_item(cru_pkg::ACT_START, 1024, 1023, 4);
        run_to_end();
    endtask

    task automatic test_midpoint_rule();
        set_rule(cru_pkg::ALG_MIDPOINT);
        send_item(cru_pkg::ACT_START, 0, 2047, 0);
        send_item(cru_pkg::ACT_START, 12, 34, 5);
        run_to_end();
    endtask

    task automatic test_rule_change_mid_circle();
        send_item(cru_pkg::ACT_START, 300, 700, 9);
        step_circle();
        set_rule(cru_pkg::ALG_BRESENHAM);
        step_circle();
        step_circle();
        set_rule(cru_pkg::ALG_MIDPOINT);
        run_to_end();
    endtask

    // Random circles: mostly small radii drawn to the end, some large ones cut
    // short by a new start, the odd rule change, and stray steps between them.
    task automatic test_random_circles(input int target);
        int drawn_at_start;
        int steps_left;
        int rad;
        drawn_at_start = items_drawn;
        while (items_drawn - drawn_at_start < target) begin
            out_stalls_on = ($urandom_range(0, 3) != 0);
            in_gaps_on    = ($urandom_range(0, 3) != 0);
            if ($urandom_range(0, 7) == 0)
                set_rule(1'($urandom_range(0, 1)));
            if ($urandom_range(0, 7) == 0) begin
                rad        = $urandom_range(0, 1023);
                steps_left = $urandom_range(0, 8);
            end else begin
                rad        = $urandom_range(0, 24);
                steps_left = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 6) : 1000;
            end
            send_item(cru_pkg::ACT_START, CW'($urandom_range(0, 2047)),
                      CW'($urandom_range(0, 2047)), (CW-1)'(rad));
            while (circle_active && steps_left > 0
                   && items_drawn - drawn_at_start < target) begin
                if ($urandom_range(0, 24) == 0)
                    set_rule(1'($urandom_range(0, 1)));
                step_circle();
                steps_left--;
            end
            if ($urandom_range(0, 3) == 0)
                step_circle();
        end
    endtask

    // Output back-pressure: runs of ready and stalls of random length.
    always @(negedge i_clk) begin
        if (!out_stalls_on) begin
            i_out_ready <= 1'b1;
            ready_hold  <= 0;
        end else if (ready_hold != 0) begin
            ready_hold <= ready_hold - 1;
        end else if (i_out_ready) begin
            i_out_ready <= 1'b0;
            ready_hold  <= pick_gap();
        end else begin
            i_out_ready <= 1'b1;
            ready_hold  <= $urandom_range(0, 12);
        end
    end

    // Compare every output transfer with the oldest predicted pixel.
    always @(posedge i_clk) begin : check_pixels
        t_pixel got;
        t_pixel want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            got = {o_pixel_x, o_pixel_y, o_last_of_group, o_circle_done};
            if (expected_pixels.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: pixel with none predicted: x=%0d y=%0d last=%0b done=%0b",
                             $realtime, $signed(got.px), $signed(got.py), got.last, got.done);
            end else begin
                want = expected_pixels.pop_front();
                pixels_checked++;
                if (got.px !== want.px || got.py !== want.py
                    || got.last !== want.last || got.done !== want.done) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("%0t: pixel mismatch: expected x=%0d y=%0d last=%0b done=%0b,",
                                 $realtime, $signed(want.px), $signed(want.py), want.last,
                                 want.done);
                        $display("    got x=%0d y=%0d last=%0b done=%0b",
                                 $signed(got.px), $signed(got.py), got.last, got.done);
                    end
                end
            end
        end
    end

    // Watchdog on cycles in which no transfer happens on any channel.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)
            || (i_cfg_valid && o_cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no transfer for %0d cycles, %0d pixels still awaited",
                     $realtime, idle_cycles, expected_pixels.size());
            $display("circle_rasterizer_unit test failed");
            $finish;
        end
    end

    // Test sequence.
    initial begin
        i_rst_n                = 1'b0;
        i_cfg_valid            = 1'b0;
        i_cfg_algorithm_select = 1'b0;
        i_in_valid             = 1'b0;
        i_action               = cru_pkg::ACT_START;
        i_center_x             = '0;
        i_center_y             = '0;
        i_radius               = '0;
        i_out_ready            = 1'b0;
        out_stalls_on          = 1'b0;
        in_gaps_on             = 1'b0;
        mismatches             = 0;
        items_sent             = 0;
        items_drawn            = 0;
        circles_started        = 0;
        pixels_checked         = 0;
        rule_writes            = 0;

        // Shadow state after reset: Bresenham rule, idle.
        rule_sel      = cru_pkg::ALG_BRESENHAM;
        off_x         = '0;
        off_y         = '0;
        decision_val  = '0;
        held_cx       = '0;
        held_cy       = '0;
        circle_active = 1'b0;

        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_step_while_idle();
        test_bresenham_extremes();
        test_midpoint_rule();
        test_rule_change_mid_circle();
        test_random_circles(RANDOM_ITEMS);

        // Drain the last pixels, then watch for anything extra.
        idle_input();
        while (expected_pixels.size() != 0)
            @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("Sent %0d items (%0d drawing) over %0d circles under both rules.",
                 items_sent, items_drawn, circles_started);
        $display("Checked %0d pixels after %0d rule writes; %0d mismatches.",
                 pixels_checked, rule_writes, mismatches);
        if (mismatches == 0)
            $display("circle_rasterizer_unit test passed");
        else
            $display("circle_rasterizer_unit test failed");
        $finish;
    end

endmodule
